[src/eqf_pkg.sv]
// shared types, constants and helpers for the eight queens enumerator
package eqf_pkg;

  localparam int BOARD_N = 8;
  localparam logic [3:0] ROW_FIRST = 4'd1;
  localparam logic [3:0] ROW_LAST = 4'd8;
  localparam logic [3:0] ROW_END = 4'd9;
  localparam logic [2:0] COL_LAST = 3'd7;

  typedef struct packed {
    logic [3:0] fixed_row;
    logic [3:0] fixed_column;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [6:0] solution_number;
    logic [3:0] queen_row_col1;
    logic [3:0] queen_row_col2;
    logic [3:0] queen_row_col3;
    logic [3:0] queen_row_col4;
    logic [3:0] queen_row_col5;
    logic [3:0] queen_row_col6;
    logic [3:0] queen_row_col7;
    logic [3:0] queen_row_col8;
    logic       last_result;
  } out_item_t;

  // index 0 is column 1
  typedef logic [BOARD_N-1:0][3:0] rows_t;

  typedef enum logic {
    EV_SOLUTION,
    EV_FINISH
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t kind;
    rows_t    rows;
  } ev_t;

  typedef struct packed {
    logic blocked;
    logic diag_hit;
  } cand_chk_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRY,
    S_DIAG,
    S_SOLN,
    S_BACK,
    S_FIN
  } state_t;

  function automatic out_item_t make_result(input logic found, input logic [6:0] num,
                                            input rows_t rows, input logic last);
    out_item_t r;
    r.found = found;
    r.solution_number = num;
    r.queen_row_col1 = rows[0];
    r.queen_row_col2 = rows[1];
    r.queen_row_col3 = rows[2];
    r.queen_row_col4 = rows[3];
    r.queen_row_col5 = rows[4];
    r.queen_row_col6 = rows[5];
    r.queen_row_col7 = rows[6];
    r.queen_row_col8 = rows[7];
    r.last_result = last;
    return r;
  endfunction

endpackage

[src/eqf_check.sv]
// candidate check unit: row/required-square test and one diagonal compare per cycle
module eqf_check (
  input  logic [3:0]         row,
  input  logic [2:0]         col,
  input  logic [7:0]         used,
  input  logic [3:0]         want_row,
  input  logic [3:0]         want_col,
  input  logic [3:0]         prev_row,
  input  logic [2:0]         gap,
  output eqf_pkg::cand_chk_t chk
);
  import eqf_pkg::*;

  logic [2:0] row_idx;
  logic [3:0] diff;

  assign row_idx = row[2:0] - 3'd1;
  assign diff = (prev_row > row) ? (prev_row - row) : (row - prev_row);

  always_comb begin
    chk.blocked = used[row_idx] ||
                  ((({1'b0, col} + 4'd1) == want_col) && (row != want_row));
    chk.diag_hit = (diff == {1'b0, gap});
  end

endmodule

[src/eqf_search.sv]
// backtracking sequencer: walks columns, checks one earlier column per cycle
module eqf_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  eqf_pkg::in_item_t in_item,
  output logic              ev_valid,
  input  logic              ev_ready,
  output eqf_pkg::ev_t      ev
);
  import eqf_pkg::*;

  state_t     state, state_next;
  logic [2:0] col, col_next;
  logic [3:0] row, row_next;
  logic [2:0] dc, dc_next;
  logic [7:0] used, used_next;
  logic [3:0] want_row, want_col;
  logic [3:0] partial [BOARD_N];
  logic       wr_en;
  logic [2:0] rd_addr;
  logic [3:0] rd_row;
  logic [2:0] row_idx, pr_idx;
  logic [2:0] gap;
  logic       in_ok;
  cand_chk_t  chk;

  assign rd_addr = (state == S_BACK) ? (col - 3'd1) : dc;
  assign rd_row = partial[rd_addr];
  assign row_idx = row[2:0] - 3'd1;
  assign pr_idx = rd_row[2:0] - 3'd1;
  assign gap = col - dc;
  assign in_ok = (in_item.fixed_row >= ROW_FIRST) && (in_item.fixed_row <= ROW_LAST) &&
                 (in_item.fixed_column >= ROW_FIRST) && (in_item.fixed_column <= ROW_LAST);

  eqf_check u_check (
    .row      (row),
    .col      (col),
    .used     (used),
    .want_row (want_row),
    .want_col (want_col),
    .prev_row (rd_row),
    .gap      (gap),
    .chk      (chk)
  );

  always_comb begin
    for (int i = 0; i < BOARD_N; i++) begin
      ev.rows[i] = partial[i];
    end
    state_next = state;
    col_next = col;
    row_next = row;
    dc_next = dc;
    used_next = used;
    wr_en = 1'b0;
    in_ready = 1'b0;
    ev_valid = 1'b0;
    ev.kind = EV_SOLUTION;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          used_next = '0;
          col_next = '0;
          row_next = ROW_FIRST;
          dc_next = '0;
          state_next = in_ok ? S_TRY : S_FIN;
        end
      end
      S_TRY: begin
        if (row == ROW_END) begin
          state_next = S_BACK;
        end else if (chk.blocked) begin
          row_next = row + 4'd1;
        end else if (col == 3'd0) begin
          wr_en = 1'b1;
          used_next = used | (8'd1 << row_idx);
          col_next = col + 3'd1;
          row_next = ROW_FIRST;
        end else begin
          dc_next = '0;
          state_next = S_DIAG;
        end
      end
      S_DIAG: begin
        if (chk.diag_hit) begin
          row_next = row + 4'd1;
          state_next = S_TRY;
        end else if (dc == col - 3'd1) begin
          // all earlier columns clear: place the queen
          wr_en = 1'b1;
          used_next = used | (8'd1 << row_idx);
          if (col == COL_LAST) begin
            state_next = S_SOLN;
          end else begin
            col_next = col + 3'd1;
            row_next = ROW_FIRST;
            state_next = S_TRY;
          end
        end else begin
          dc_next = dc + 3'd1;
        end
      end
      S_SOLN: begin
        ev_valid = 1'b1;
        if (ev_ready) begin
          used_next = used & ~(8'd1 << row_idx);
          row_next = row + 4'd1;
          state_next = S_TRY;
        end
      end
      S_BACK: begin
        if (col == 3'd0) begin
          state_next = S_FIN;
        end else begin
          // resume the previous column at the row after its queen
          col_next = col - 3'd1;
          row_next = rd_row + 4'd1;
          used_next = used & ~(8'd1 << pr_idx);
          state_next = S_TRY;
        end
      end
      S_FIN: begin
        ev_valid = 1'b1;
        ev.kind = EV_FINISH;
        if (ev_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    col <= col_next;
    row <= row_next;
    dc <= dc_next;
    used <= used_next;
    if (in_valid && in_ready) begin
      want_row <= in_item.fixed_row;
      want_col <= in_item.fixed_column;
    end
    if (wr_en) begin
      partial[col] <= row;
    end
  end

endmodule

[src/eqf_result_buf.sv]
// holds one placement back so the final one can carry the last flag, plus output register
module eqf_result_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               ev_valid,
  output logic               ev_ready,
  input  eqf_pkg::ev_t       ev,
  output logic               out_valid,
  input  logic               out_ready,
  output eqf_pkg::out_item_t out_data
);
  import eqf_pkg::*;

  logic       pend_valid;
  rows_t      pend_rows;
  logic [6:0] count;
  logic       out_free;
  logic       ev_take;

  assign out_free = !out_valid || out_ready;
  assign ev_ready = (ev.kind == EV_SOLUTION) ? (!pend_valid || out_free) : out_free;
  assign ev_take = ev_valid && ev_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ev_take && ev.kind == EV_SOLUTION) begin
        pend_valid <= 1'b1;
        count <= count + 7'd1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (ev_take) begin
        pend_valid <= 1'b0;
        count <= '0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_take && ev.kind == EV_SOLUTION) begin
      pend_rows <= ev.rows;
      if (pend_valid) begin
        out_data <= make_result(1'b1, count, pend_rows, 1'b0);
      end
    end else if (ev_take) begin
      // search done: flush the held placement as last, or report none
      out_data <= pend_valid ? make_result(1'b1, count, pend_rows, 1'b1)
                             : make_result(1'b0, 7'd0, '0, 1'b1);
    end
  end

endmodule

[src/eight_queens_fixed_queen_enumerator.sv]
// eight queens with one required queen: top level
// one item at a time; the search tries one candidate row or earlier column per cycle,
// except while a result or the finish waits for the result buffer to accept it
// results leave through one output register; the block takes no new item until the search ends
// out-of-range squares skip the search and give the single not-found result
// synchronous reset clears the sequencer and output valid; the row store needs no clearing
module eight_queens_fixed_queen_enumerator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  eqf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output eqf_pkg::out_item_t out_data
);
  import eqf_pkg::*;

  logic ev_valid;
  logic ev_ready;
  ev_t  ev;

  eqf_search u_search (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_data),
    .ev_valid (ev_valid),
    .ev_ready (ev_ready),
    .ev       (ev)
  );

  eqf_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
